@@ rtl/led_cf_pkg.sv @@
// Shared types, register indexes, mode codes and arithmetic constants of the LED colour fader.
package led_cf_pkg;

    // Default number of LEDs kept in the colour memories.
    localparam int LED_COUNT_DEF = 29;

    // Item operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Tick mode codes.
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_WIFI  = 3'd2;
    localparam logic [2:0] MODE_FADE  = 3'd3;
    localparam logic [2:0] MODE_ERROR = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic       REG_STEP_SIZE   = 1'b0;
    localparam logic       REG_IGNORED_LED = 1'b1;
    localparam logic [7:0] STEP_SIZE_RST   = 8'd10;
    localparam logic [6:0] IGNORED_LED_RST = 7'd27;

    // Brightness mapping constants.
    localparam logic [10:0] LEVEL_SPAN  = 11'd1024;
    localparam logic [7:0]  MAP_SCALE   = 8'd237;
    localparam logic [13:0] RECIP_7     = 14'd9363;      // ceil(2^16 / 7)
    localparam logic [11:0] BRIGHT_MIN  = 12'd18;
    localparam logic [11:0] BRIGHT_MAX  = 12'd255;
    localparam logic [6:0]  KEEP_WEIGHT = 7'd97;
    localparam logic [9:0]  NEW_WEIGHT  = 10'd768;
    localparam logic [23:0] RECIP_100   = 24'd10737419;  // ceil(2^30 / 100)

    // Blink timing constants.
    localparam logic [28:0] RECIP_1000 = 29'h10624DD3;   // ceil(2^38 / 1000)
    localparam logic [9:0]  PERIOD_MS  = 10'd1000;
    localparam logic [31:0] FLASH_MS   = 32'd200;

    // One RGB colour.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // Status handed from the brightness unit to the sequencer.
    typedef struct packed {
        logic       done;
        logic       err_on;
        logic       wifi_on;
        logic [7:0] brightness;
    } bright_status_t;

endpackage

@@ rtl/led_cf_item_if.sv @@
// Input channel carrying tick and target write transactions.
interface led_cf_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  mode;
    logic [31:0] time_ms;
    logic [9:0]  light_level;
    logic [5:0]  led_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;

    modport source (
        output valid, op, mode, time_ms, light_level, led_index, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, op, mode, time_ms, light_level, led_index, red_in, green_in, blue_in,
        output ready
    );
endinterface

@@ rtl/led_cf_pixel_if.sv @@
// Output channel carrying one LED report transaction.
interface led_cf_pixel_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] brightness_out;
    logic       last;

    modport source (
        output valid, led_out, red_out, green_out, blue_out, brightness_out, last,
        input  ready
    );
    modport sink (
        input  valid, led_out, red_out, green_out, blue_out, brightness_out, last,
        output ready
    );
endinterface

@@ rtl/led_cf_color_mem.sv @@
// Current and target colour memories with per-entry valid bits and registered reads.
module led_cf_color_mem #(
    parameter int LED_COUNT = led_cf_pkg::LED_COUNT_DEF,
    parameter int AW        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tgt_we,
    input  logic [AW-1:0]        tgt_waddr,
    input  led_cf_pkg::color_t   tgt_wdata,
    input  logic                 cur_we,
    input  logic [AW-1:0]        cur_waddr,
    input  led_cf_pkg::color_t   cur_wdata,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output led_cf_pkg::color_t   cur_rdata,
    output led_cf_pkg::color_t   tgt_rdata
);
    import led_cf_pkg::*;

    color_t               cur_mem [LED_COUNT];
    color_t               tgt_mem [LED_COUNT];
    logic [LED_COUNT-1:0] cur_vld_reg;
    logic [LED_COUNT-1:0] tgt_vld_reg;
    color_t               cur_q_reg;
    color_t               tgt_q_reg;
    logic                 cur_hit_reg;
    logic                 tgt_hit_reg;

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
    end

    // Memory reads, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_q_reg <= cur_mem[rd_addr];
            tgt_q_reg <= tgt_mem[rd_addr];
        end
    end

    // Valid bits make entries read as black until they are first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= '0;
            tgt_vld_reg <= '0;
            cur_hit_reg <= 1'b0;
            tgt_hit_reg <= 1'b0;
        end
        else
        begin
            if (cur_we)
            begin
                cur_vld_reg[cur_waddr] <= 1'b1;
            end
            if (tgt_we)
            begin
                tgt_vld_reg[tgt_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                cur_hit_reg <= cur_vld_reg[rd_addr];
                tgt_hit_reg <= tgt_vld_reg[rd_addr];
            end
        end
    end

    assign cur_rdata = cur_hit_reg ? cur_q_reg : '0;
    assign tgt_rdata = tgt_hit_reg ? tgt_q_reg : '0;

endmodule

@@ rtl/led_cf_bright.sv @@
// Four-stage arithmetic pipeline for the smoothed brightness and the blink phase.
module led_cf_bright (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  time_ms,
    input  logic [9:0]                   light_level,
    output led_cf_pkg::bright_status_t   status
);
    import led_cf_pkg::*;

    logic [3:0]  stage_vld_reg;
    logic [15:0] sb_reg;
    logic [15:0] sb_next;
    logic [17:0] scaled_reg;
    logic [22:0] kept_reg;
    logic [22:0] sec_reg;
    logic [31:0] time_reg;
    logic [26:0] div7_reg;
    logic        err_on_reg;
    logic        wifi_on_reg;
    logic [22:0] sum_reg;
    logic [10:0] inv_level;
    logic [60:0] sec_prod;
    logic [31:0] rem_ms;
    logic [11:0] target_raw;
    logic [7:0]  target;
    logic [46:0] avg_prod;

    // Stage one: scale the inverted light level, weight the old value, split off seconds.
    assign inv_level = LEVEL_SPAN - {1'b0, light_level};
    assign sec_prod  = 61'(time_ms) * 61'(RECIP_1000);

    // Stage two: divide by 224 as a shift and a reciprocal of 7, and find the millisecond phase.
    assign rem_ms = time_reg - 32'(sec_reg * PERIOD_MS);

    // Stage three: offset and clamp the target, then blend.
    assign target_raw = {1'b0, div7_reg[26:16]} + BRIGHT_MIN;
    assign target     = (target_raw > BRIGHT_MAX) ? BRIGHT_MAX[7:0] : target_raw[7:0];

    // Stage four: divide the blend by 100 through a reciprocal.
    assign avg_prod = 47'(sum_reg) * 47'(RECIP_100);
    assign sb_next  = avg_prod[45:30];

    // Pipeline data registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            scaled_reg <= 18'(inv_level * MAP_SCALE);
            kept_reg   <= 23'(sb_reg * KEEP_WEIGHT);
            sec_reg    <= sec_prod[60:38];
            time_reg   <= time_ms;
        end
        if (stage_vld_reg[0])
        begin
            div7_reg    <= 27'(scaled_reg[17:5] * RECIP_7);
            err_on_reg  <= sec_reg[0];
            wifi_on_reg <= (rem_ms < FLASH_MS);
        end
        if (stage_vld_reg[1])
        begin
            sum_reg <= kept_reg + 23'(target * NEW_WEIGHT);
        end
    end

    // Stage tracking and the Q8.8 brightness state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
            sb_reg        <= '0;
        end
        else
        begin
            stage_vld_reg <= {stage_vld_reg[2:0], start};
            if (stage_vld_reg[2])
            begin
                sb_reg <= sb_next;
            end
        end
    end

    assign status.done       = stage_vld_reg[3];
    assign status.err_on     = err_on_reg;
    assign status.wifi_on    = wifi_on_reg;
    assign status.brightness = sb_reg[15:8];

endmodule

@@ rtl/led_color_fader.sv @@
// Top level of the LED colour fader: item decode, tick sequencer and LED report register.
//
// The fader keeps a current and a target colour for each of LED_COUNT LEDs in two
// synchronous memories. A target write transaction gives no report. A tick transaction
// first runs through the brightness and blink-phase pipeline, then sweeps the colour
// memory with a read-modify-write of one LED per cycle while the sink takes every report;
// a stalled sink holds the sweep. The input is ready again as soon as the final report
// sits in the output register. After reset both memories read as black through
// per-entry valid bits, so no clearing pass is needed.
module led_color_fader #(
    parameter int LED_COUNT = led_cf_pkg::LED_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    led_cf_item_if.sink          items,
    led_cf_pixel_if.source       pixels,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);
    import led_cf_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CW = $clog2(LED_COUNT + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PREP  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [7:0]     step_size_reg;
    logic [6:0]     ignored_led_reg;
    logic [2:0]     mode_reg;
    logic [CW-1:0]  rd_cnt_reg;
    logic           rd_pend_reg;
    logic [AW-1:0]  rd_led_reg;
    logic           out_valid_reg;
    logic [5:0]     out_led_reg;
    color_t         out_color_reg;
    logic [7:0]     out_bright_reg;
    logic           out_last_reg;
    logic           accept;
    logic           tick_start;
    logic           tgt_we;
    logic           issue;
    logic           consume;
    logic           is_last;
    logic           is_ignored;
    color_t         tgt_wdata;
    color_t         cur_rdata;
    color_t         tgt_rdata;
    color_t         new_color;
    bright_status_t bstat;

    // Move one channel toward its target, snapping when within one step.
    function automatic logic [7:0] fade_ch(input logic [7:0] c, input logic [7:0] t,
                                           input logic [7:0] s);
        logic [7:0] res;
        logic [8:0] c_up;
        logic [8:0] t_up;
        c_up = {1'b0, c} + {1'b0, s};
        t_up = {1'b0, t} + {1'b0, s};
        if (t == c)
        begin
            res = c;
        end
        else if (c_up < {1'b0, t})
        begin
            res = c + s;
        end
        else if (t_up < {1'b0, c})
        begin
            res = c - s;
        end
        else
        begin
            res = t;
        end
        return res;
    endfunction

    // Input decode.
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign tick_start  = accept && (items.op == OP_TICK);
    assign tgt_we      = accept && (items.op == OP_WRITE) &&
                         ({1'b0, items.led_index} < 7'(LED_COUNT));
    assign tgt_wdata   = '{red: items.red_in, green: items.green_in, blue: items.blue_in};

    // Sweep control: a read is issued only when the read data register will be free.
    assign consume    = rd_pend_reg && (!out_valid_reg || pixels.ready);
    assign issue      = (state_reg == ST_SWEEP) && (rd_cnt_reg < CW'(LED_COUNT)) &&
                        (!rd_pend_reg || consume);
    assign is_last    = (rd_led_reg == AW'(LED_COUNT - 1));
    assign is_ignored = (7'(rd_led_reg) == ignored_led_reg);

    led_cf_color_mem #(
        .LED_COUNT (LED_COUNT),
        .AW        (AW)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .tgt_we    (tgt_we),
        .tgt_waddr (items.led_index[AW-1:0]),
        .tgt_wdata (tgt_wdata),
        .cur_we    (consume),
        .cur_waddr (rd_led_reg),
        .cur_wdata (new_color),
        .rd_en     (issue),
        .rd_addr   (rd_cnt_reg[AW-1:0]),
        .cur_rdata (cur_rdata),
        .tgt_rdata (tgt_rdata)
    );

    led_cf_bright u_bright (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (tick_start),
        .time_ms     (items.time_ms),
        .light_level (items.light_level),
        .status      (bstat)
    );

    // New colour of the LED whose data has just been read.
    always_comb
    begin
        new_color = cur_rdata;
        case (mode_reg)
            MODE_FADE:
            begin
                new_color.red   = fade_ch(cur_rdata.red, tgt_rdata.red, step_size_reg);
                new_color.green = fade_ch(cur_rdata.green, tgt_rdata.green, step_size_reg);
                new_color.blue  = fade_ch(cur_rdata.blue, tgt_rdata.blue, step_size_reg);
            end
            MODE_ERROR:
            begin
                if (!is_ignored)
                begin
                    new_color = '{red: bstat.err_on ? 8'hFF : 8'h00, green: 8'h00,
                                  blue: 8'h00};
                end
            end
            MODE_WIFI:
            begin
                if (!is_ignored)
                begin
                    new_color = '{red: 8'h00, green: 8'h00,
                                  blue: bstat.wifi_on ? 8'hFF : 8'h00};
                end
            end
            default:
            begin
                new_color = cur_rdata;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (bstat.done)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (consume && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_size_reg   <= STEP_SIZE_RST;
            ignored_led_reg <= IGNORED_LED_RST;
            rd_cnt_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_SIZE:   step_size_reg   <= cfg_data;
                    REG_IGNORED_LED: ignored_led_reg <= cfg_data[6:0];
                    default:         step_size_reg   <= step_size_reg;
                endcase
            end
            if (state_reg == ST_PREP)
            begin
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (consume)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: tick mode, read tracking and the LED report.
    always_ff @(posedge clk)
    begin
        if (tick_start)
        begin
            mode_reg <= items.mode;
        end
        if (issue)
        begin
            rd_led_reg <= rd_cnt_reg[AW-1:0];
        end
        if (consume)
        begin
            out_led_reg    <= 6'(rd_led_reg);
            out_color_reg  <= new_color;
            out_bright_reg <= bstat.brightness;
            out_last_reg   <= is_last;
        end
    end

    // Report transaction.
    assign pixels.valid          = out_valid_reg;
    assign pixels.led_out        = out_led_reg;
    assign pixels.red_out        = out_color_reg.red;
    assign pixels.green_out      = out_color_reg.green;
    assign pixels.blue_out       = out_color_reg.blue;
    assign pixels.brightness_out = out_bright_reg;
    assign pixels.last           = out_last_reg;

endmodule
